// File: rtl/hcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_pkg
// shared constants and codes of the huffman code builder
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int unsigned SYMBOLS       = 256;
  localparam int unsigned NODES         = 2 * SYMBOLS - 1;
  localparam int unsigned MAX_CODE_BITS = 64;

  localparam int unsigned SYM_W  = 8;
  localparam int unsigned NODE_W = 9;
  localparam int unsigned LEAF_W = 32;
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned BITS_W = 64;
  localparam int unsigned LEN_W  = 8;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_TREE = 2'd1;
  localparam logic [1:0] ST_NO_CODE = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

endpackage

`default_nettype wire

// File: rtl/hcb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_in_if / hcb_out_if
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface hcb_in_if;
  import hcb_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [SYM_W-1:0]  symbol;
  logic [LEAF_W-1:0] weight;
  modport source (output valid, action, symbol, weight, input ready);
  modport sink   (input valid, action, symbol, weight, output ready);
endinterface

interface hcb_out_if;
  import hcb_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [BITS_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  modport source (output valid, status, code_bits, code_length, input ready);
  modport sink   (input valid, status, code_bits, code_length, output ready);
endinterface

`default_nettype wire

// File: rtl/huffman_code_builder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_code_builder_core
// weight store, tree build by repeated minimum scans, code lookup by leaf walk
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_i    | in  | action, symbol, weight
//  out_o   | out | status, code_bits, code_length
//
//  load and ignored actions: result registered at acceptance
//  build: node memory clear + slot fill, then per merge two scans of the
//    slot memory read port plus the S_MRG1 and S_MRG2 write states
//  query: one tree level per cycle, walking the node memory
//  reset clears weights (valid bits), tree flag and control; no input item
//    is taken while a build or query runs or a result is held and stalled
// ----------------------------------------------------------------------------
module huffman_code_builder_core import hcb_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  hcb_in_if.sink   in_i,
  hcb_out_if.source out_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MRG1  = 4'd4;
  localparam logic [3:0] S_MRG2  = 4'd5;
  localparam logic [3:0] S_QRD   = 4'd6;
  localparam logic [3:0] S_QWALK = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam int unsigned SLOT_W = 1 + NODE_W + SUM_W;
  localparam int unsigned NMEM_W = 2 + NODE_W;

  // memories
  logic [LEAF_W-1:0] leaf_mem [SYMBOLS];
  logic [SLOT_W-1:0] slot_mem [SYMBOLS];
  logic [NMEM_W-1:0] node_mem [NODES];

  logic              leaf_we;
  logic [SYM_W-1:0]  leaf_waddr, leaf_raddr;
  logic [LEAF_W-1:0] leaf_wdata, leaf_rdata_q;
  logic              slot_we;
  logic [SYM_W-1:0]  slot_waddr, slot_raddr;
  logic [SLOT_W-1:0] slot_wdata, slot_rdata_q;
  logic              node_we;
  logic [NODE_W-1:0] node_waddr, node_raddr;
  logic [NMEM_W-1:0] node_wdata, node_rdata_q;

  logic [SYMBOLS-1:0] leaf_vld_q, leaf_vld_d;
  logic               leaf_vrd_q;

  always_ff @(posedge clk_i) begin
    if (leaf_we) leaf_mem[leaf_waddr] <= leaf_wdata;
    leaf_rdata_q <= leaf_mem[leaf_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rdata_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata_q <= node_mem[node_raddr];
  end

  // read data fields
  logic              sl_live;
  logic [NODE_W-1:0] sl_node;
  logic [SUM_W-1:0]  sl_w;
  logic              nd_right, nd_has;
  logic [NODE_W-1:0] nd_parent;
  assign {sl_live, sl_node, sl_w}     = slot_rdata_q;
  assign {nd_right, nd_parent, nd_has} = node_rdata_q;

  logic [3:0]        state_q, state_d;
  logic [NODE_W-1:0] cnt_q, cnt_d;
  logic              pv_q, pv_d;
  logic [SYM_W-1:0]  pi_q, pi_d;
  logic              pass_q, pass_d;
  logic              found_q, found_d;
  logic [SUM_W-1:0]  bw_q, bw_d;
  logic [SYM_W-1:0]  bi_q, bi_d;
  logic [NODE_W-1:0] bn_q, bn_d;
  logic [SUM_W-1:0]  aw_q, aw_d;
  logic [SYM_W-1:0]  ai_q, ai_d;
  logic [NODE_W-1:0] an_q, an_d;
  logic [NODE_W-1:0] next_q, next_d;
  logic              built_q, built_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic              first_q, first_d;
  logic [NODE_W-1:0] len_q, len_d;
  logic [BITS_W-1:0] bits_q, bits_d;
  logic [1:0]        rst_q, rst_d;
  logic              ov_q, ov_d;
  logic [1:0]        ost_q, ost_d;
  logic [BITS_W-1:0] obits_q, obits_d;
  logic [LEN_W-1:0]  olen_q, olen_d;

  logic              out_free, cand, last;
  logic [LEAF_W-1:0] lw;

  assign out_free    = !ov_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign out_o.valid       = ov_q;
  assign out_o.status      = ost_q;
  assign out_o.code_bits   = obits_q;
  assign out_o.code_length = olen_q;

  assign lw   = leaf_vrd_q ? leaf_rdata_q : '0;
  assign last = pv_q && (pi_q == SYM_W'(SYMBOLS - 1));
  assign cand = pv_q && sl_live && !(pass_q && (pi_q == ai_q)) && (!found_q || sl_w < bw_q);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; pv_d = 1'b0; pi_d = pi_q; pass_d = pass_q;
    found_d = found_q; bw_d = bw_q; bi_d = bi_q; bn_d = bn_q;
    aw_d = aw_q; ai_d = ai_q; an_d = an_q; next_d = next_q; built_d = built_q;
    sym_d = sym_q; first_d = first_q; len_d = len_q; bits_d = bits_q; rst_d = rst_q;
    ov_d = ov_q && !out_o.ready; ost_d = ost_q; obits_d = obits_q; olen_d = olen_q;
    leaf_vld_d = leaf_vld_q;
    leaf_we = 1'b0; leaf_waddr = in_i.symbol; leaf_wdata = in_i.weight;
    leaf_raddr = cnt_q[SYM_W-1:0];
    slot_we = 1'b0; slot_waddr = pi_q; slot_wdata = '0; slot_raddr = cnt_q[SYM_W-1:0];
    node_we = 1'b0; node_waddr = cnt_q; node_wdata = '0; node_raddr = nd_parent;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.ready) begin
          case (in_i.action)
            ACT_BUILD: begin
              state_d = S_CLR;
              cnt_d   = '0;
              next_d  = NODE_W'(SYMBOLS);
            end
            ACT_QUERY: begin
              sym_d = in_i.symbol;
              if (!built_q) begin
                ov_d = 1'b1; ost_d = ST_NO_TREE; obits_d = '0; olen_d = '0;
              end else begin
                state_d = S_QRD;
              end
            end
            default: begin
              if (in_i.action == ACT_LOAD) begin
                leaf_we = 1'b1;
                leaf_vld_d[in_i.symbol] = 1'b1;
              end
              ov_d = 1'b1; ost_d = ST_OK; obits_d = '0; olen_d = '0;
            end
          endcase
        end
      end
      S_CLR: begin
        node_we = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == NODE_W'(NODES - 1)) begin
          state_d = S_INIT;
          cnt_d   = '0;
        end
      end
      S_INIT: begin
        if (!cnt_q[NODE_W-1]) begin
          cnt_d = cnt_q + 1'b1; pv_d = 1'b1; pi_d = cnt_q[SYM_W-1:0];
        end
        if (pv_q) begin
          slot_we    = 1'b1;
          slot_wdata = {lw != '0, 1'b0, pi_q, SUM_W'(lw)};
        end
        if (last) begin
          state_d = S_SCAN; cnt_d = '0; pv_d = 1'b0; pass_d = 1'b0; found_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (!cnt_q[NODE_W-1]) begin
          cnt_d = cnt_q + 1'b1; pv_d = 1'b1; pi_d = cnt_q[SYM_W-1:0];
        end
        if (cand) begin
          found_d = 1'b1; bw_d = sl_w; bi_d = pi_q; bn_d = sl_node;
        end
        if (last) begin
          cnt_d = '0; pv_d = 1'b0; found_d = 1'b0;
          if (!pass_q) begin
            if (!(found_q || cand)) begin
              built_d = 1'b0; rst_d = ST_NO_TREE; len_d = '0; bits_d = '0;
              state_d = S_DONE;
            end else begin
              aw_d = bw_d; ai_d = bi_d; an_d = bn_d; pass_d = 1'b1;
            end
          end else if (!(found_q || cand) || next_q >= NODE_W'(NODES)) begin
            built_d = 1'b1; rst_d = ST_OK; len_d = '0; bits_d = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_MRG1;
          end
        end
      end
      S_MRG1: begin
        node_we = 1'b1; node_waddr = an_q; node_wdata = {1'b0, next_q, 1'b1};
        slot_we = 1'b1; slot_waddr = ai_q; slot_wdata = {1'b1, next_q, aw_q + bw_q};
        state_d = S_MRG2;
      end
      S_MRG2: begin
        node_we = 1'b1; node_waddr = bn_q; node_wdata = {1'b1, next_q, 1'b1};
        slot_we = 1'b1; slot_waddr = bi_q; slot_wdata = {1'b0, bn_q, bw_q};
        next_d  = next_q + 1'b1;
        pass_d  = 1'b0;
        state_d = S_SCAN;
      end
      S_QRD: begin
        node_raddr = {1'b0, sym_q};
        slot_raddr = sym_q;
        first_d = 1'b1; len_d = '0; bits_d = '0;
        state_d = S_QWALK;
      end
      S_QWALK: begin
        first_d = 1'b0;
        if (nd_has) begin
          if (nd_right && len_q < NODE_W'(MAX_CODE_BITS)) bits_d[len_q[5:0]] = 1'b1;
          len_d = len_q + 1'b1;
        end else begin
          state_d = S_DONE;
          if (first_q) begin
            rst_d = (sl_live && sl_node == {1'b0, sym_q}) ? ST_OK : ST_NO_CODE;
          end else if (len_q > NODE_W'(MAX_CODE_BITS)) begin
            rst_d = ST_TOO_LONG; bits_d = '0;
          end else begin
            rst_d = ST_OK;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_d = 1'b1; ost_d = rst_q; obits_d = bits_q; olen_d = len_q[LEN_W-1:0];
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; pv_q <= 1'b0; pass_q <= 1'b0; found_q <= 1'b0;
      next_q <= NODE_W'(SYMBOLS); built_q <= 1'b0; first_q <= 1'b0;
      ov_q <= 1'b0; leaf_vld_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; pv_q <= pv_d; pass_q <= pass_d;
      found_q <= found_d; next_q <= next_d; built_q <= built_d; first_q <= first_d;
      ov_q <= ov_d; leaf_vld_q <= leaf_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pi_q <= pi_d; bw_q <= bw_d; bi_q <= bi_d; bn_q <= bn_d;
    aw_q <= aw_d; ai_q <= ai_d; an_q <= an_d; sym_q <= sym_d;
    len_q <= len_d; bits_q <= bits_d; rst_q <= rst_d;
    ost_q <= ost_d; obits_q <= obits_d; olen_q <= olen_d;
    leaf_vrd_q <= leaf_vld_q[leaf_raddr];
  end

endmodule

`default_nettype wire
